// ----- rtl/core/tbslc_pkg.sv -----
// tbslc_pkg: shared types and constants of the two-bit symbol line codec
// holds payload structs, config struct, register index codes and reset values
// no dependencies
package tbslc_pkg;

  localparam int unsigned SymW       = 8;
  localparam int unsigned MapW       = 32;
  localparam int unsigned AlignW     = 2;
  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = 3;

  localparam logic [MapW-1:0]   SYMBOL_MAP_RESET = 32'hDBFBDFFF;
  localparam logic              FIRST_HIGH_RESET = 1'b1;
  localparam logic [AlignW-1:0] ALIGN_RESET      = 2'd0;

  typedef enum logic {
    ACT_DECODE = 1'b0,
    ACT_ENCODE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    REG_SYMBOL_MAP = 2'd0,
    REG_FIRST_HIGH = 2'd1,
    REG_ALIGN      = 2'd2
  } reg_index_t;

  typedef struct packed {
    action_t         action;
    logic [SymW-1:0] data;
    logic            last;
  } in_t;

  typedef struct packed {
    logic [SymW-1:0] out_byte;
    logic            run_last;
  } out_t;

  typedef struct packed {
    logic [MapW-1:0]   symbol_map;
    logic              first_high;
    logic [AlignW-1:0] align;
  } cfg_t;

  // results produced by one item, slot 0 goes out first
  typedef struct packed {
    logic [CntW-1:0]           count;
    out_t [MaxResults-1:0]     items;
  } res_set_t;

  typedef struct packed {
    logic            can_load;
    logic [CntW-1:0] count;
  } ser_stat_t;

endpackage

// ----- rtl/core/two_bit_symbol_line_codec.sv -----
// two_bit_symbol_line_codec: top level of the two-bit-per-symbol line codec
// depends on tbslc_pkg, tbslc_decoder, tbslc_encoder, tbslc_out_ser
//
// Line codec in which each line symbol byte carries one bit pair. A decode item
// (action 0) brings one symbol; after skipping align symbols at the start of a
// buffer, every four known symbols give one data byte, and an unknown symbol
// stops decoding until the item marked last. An encode item (action 1) brings a
// data byte and yields four symbols, run_last on the fourth. An item enters an
// input register, is worked in one pass through short logic and moves into a
// result register, so input and output are parted by two registers and the
// input register can take one more item while results wait. A decode item
// gives at most one result; an encode item holds the single result channel for
// four output transactions, so a stream of encodes is paced by that channel.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must
// write it only while idle, the block itself does not enforce this.
module two_bit_symbol_line_codec (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tbslc_pkg::in_t             in_item,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output tbslc_pkg::out_t            out_item,
  // configuration write port
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [tbslc_pkg::MapW-1:0] cfg_data
);

  // configuration registers
  tbslc_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.symbol_map <= tbslc_pkg::SYMBOL_MAP_RESET;
      cfg.first_high <= tbslc_pkg::FIRST_HIGH_RESET;
      cfg.align      <= tbslc_pkg::ALIGN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbslc_pkg::REG_SYMBOL_MAP: cfg.symbol_map <= cfg_data;
        tbslc_pkg::REG_FIRST_HIGH: cfg.first_high <= cfg_data[0];
        tbslc_pkg::REG_ALIGN:      cfg.align      <= cfg_data[tbslc_pkg::AlignW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // input register
  logic                 in_full;
  tbslc_pkg::in_t       in_hold;
  logic                 advance;
  tbslc_pkg::ser_stat_t ser_stat;

  assign advance  = in_full && ser_stat.can_load;
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_hold <= in_item;
    end
  end

  // one pass of work on the held item
  logic                                        dec_step;
  logic                                        dec_valid;
  logic [tbslc_pkg::SymW-1:0]                  dec_byte;
  tbslc_pkg::out_t [tbslc_pkg::MaxResults-1:0] enc_syms;
  tbslc_pkg::res_set_t                         res_set;
  logic                                        is_encode;

  assign is_encode = (in_hold.action == tbslc_pkg::ACT_ENCODE);
  assign dec_step  = advance && !is_encode;

  tbslc_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (dec_step),
    .sym       (in_hold.data),
    .last      (in_hold.last),
    .res_valid (dec_valid),
    .res_byte  (dec_byte)
  );

  tbslc_encoder u_encoder (
    .cfg  (cfg),
    .data (in_hold.data),
    .syms (enc_syms)
  );

  // encode fills all four slots; decode leaves zero or one byte in slot 0
  always_comb begin
    if (is_encode) begin
      res_set.count = tbslc_pkg::CntW'(tbslc_pkg::MaxResults);
      res_set.items = enc_syms;
    end else begin
      res_set.count             = tbslc_pkg::CntW'(dec_valid);
      res_set.items             = enc_syms;
      res_set.items[0].out_byte = dec_byte;
      res_set.items[0].run_last = 1'b1;
    end
  end

  tbslc_out_ser u_out_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .set       (res_set),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .stat      (ser_stat)
  );

`ifndef SYNTHESIS
  // a held item that cannot move on stays held
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> in_full)
    else $error("held item lost while result register busy");

  // an encode item always leaves four results waiting
  a_encode_four: assert property (@(posedge clk) disable iff (rst)
    (advance && is_encode) |=> (ser_stat.count == tbslc_pkg::CntW'(tbslc_pkg::MaxResults)))
    else $error("encode transaction did not load four symbols");

  // result count never exceeds four
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    ser_stat.count <= tbslc_pkg::CntW'(tbslc_pkg::MaxResults))
    else $error("result count out of range");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_full))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ----- rtl/core/tbslc_encoder.sv -----
// tbslc_encoder: maps one data byte onto its four line symbols
// depends on tbslc_pkg
module tbslc_encoder (
  input  tbslc_pkg::cfg_t                             cfg,
  input  logic [tbslc_pkg::SymW-1:0]                  data,
  output tbslc_pkg::out_t [tbslc_pkg::MaxResults-1:0] syms
);

  // pair of symbol k sits at bits 2k+1:2k
  logic [tbslc_pkg::SymW-1:0] ordered;
  logic [1:0]                 pair;

  assign ordered = cfg.first_high ? {data[1:0], data[3:2], data[5:4], data[7:6]} : data;

  always_comb begin
    pair = 2'd0;
    for (int k = 0; k < tbslc_pkg::MaxResults; k++) begin
      pair                = ordered[2*k +: 2];
      syms[k].out_byte    = cfg.symbol_map[{pair, 3'b000} +: tbslc_pkg::SymW];
      syms[k].run_last    = (k == tbslc_pkg::MaxResults - 1);
    end
  end

endmodule

// ----- rtl/core/tbslc_decoder.sv -----
// tbslc_decoder: buffer alignment, symbol lookup and group packing state
// depends on tbslc_pkg
module tbslc_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  tbslc_pkg::cfg_t            cfg,
  input  logic                       step,
  input  logic [tbslc_pkg::SymW-1:0] sym,
  input  logic                       last,
  output logic                       res_valid,
  output logic [tbslc_pkg::SymW-1:0] res_byte
);

  logic [1:0] skip_left, skip_left_next;
  logic [1:0] group_count, group_count_next;
  logic [5:0] partial_bits, partial_bits_next;
  logic       halted, halted_next;
  logic       buffer_start, buffer_start_next;

  logic [1:0] skip_eff;
  logic       hit;
  logic [1:0] q;

  // lowest matching pair wins
  always_comb begin
    hit = 1'b1;
    q   = 2'd0;
    priority if (cfg.symbol_map[7:0] == sym)   q = 2'd0;
    else if (cfg.symbol_map[15:8] == sym)      q = 2'd1;
    else if (cfg.symbol_map[23:16] == sym)     q = 2'd2;
    else if (cfg.symbol_map[31:24] == sym)     q = 2'd3;
    else                                       hit = 1'b0;
  end

  assign skip_eff = buffer_start ? cfg.align : skip_left;

  always_comb begin
    skip_left_next    = skip_eff;
    group_count_next  = group_count;
    partial_bits_next = partial_bits;
    halted_next       = halted;
    buffer_start_next = 1'b0;
    res_valid         = 1'b0;
    res_byte          = cfg.first_high ? {partial_bits, q}
                                       : {q, partial_bits[1:0], partial_bits[3:2],
                                          partial_bits[5:4]};
    if (!halted) begin
      if (skip_eff != 2'd0) begin
        skip_left_next = skip_eff - 2'd1;
      end else if (!hit) begin
        halted_next       = 1'b1;
        group_count_next  = 2'd0;
        partial_bits_next = 6'd0;
      end else if (group_count != 2'd3) begin
        partial_bits_next = {partial_bits[3:0], q};
        group_count_next  = group_count + 2'd1;
      end else begin
        res_valid         = 1'b1;
        group_count_next  = 2'd0;
        partial_bits_next = 6'd0;
      end
    end
    if (last) begin
      group_count_next  = 2'd0;
      partial_bits_next = 6'd0;
      halted_next       = 1'b0;
      skip_left_next    = 2'd0;
      buffer_start_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_left    <= 2'd0;
      group_count  <= 2'd0;
      partial_bits <= 6'd0;
      halted       <= 1'b0;
      buffer_start <= 1'b1;
    end else if (step) begin
      skip_left    <= skip_left_next;
      group_count  <= group_count_next;
      partial_bits <= partial_bits_next;
      halted       <= halted_next;
      buffer_start <= buffer_start_next;
    end
  end

endmodule

// ----- rtl/core/tbslc_out_ser.sv -----
// tbslc_out_ser: result register that hands out up to four results, one per transaction
// depends on tbslc_pkg
module tbslc_out_ser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  tbslc_pkg::res_set_t   set,
  input  logic                  out_ready,
  output logic                  out_valid,
  output tbslc_pkg::out_t       out_item,
  output tbslc_pkg::ser_stat_t  stat
);

  tbslc_pkg::out_t [tbslc_pkg::MaxResults-1:0] slot;
  logic [tbslc_pkg::CntW-1:0]                  cnt;
  logic                                        pop;

  assign out_valid     = (cnt != '0);
  assign out_item      = slot[0];
  assign pop           = out_valid && out_ready;
  assign stat.count    = cnt;
  assign stat.can_load = (cnt == '0) || ((cnt == tbslc_pkg::CntW'(1)) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= set.count;
    end else if (pop) begin
      cnt <= cnt - tbslc_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= set.items;
    end else if (pop) begin
      for (int i = 0; i < tbslc_pkg::MaxResults - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

endmodule

// ----- sim/two_bit_symbol_line_codec_test.sv -----
`timescale 1ns / 100ps
// two_bit_symbol_line_codec_test: self-checking bench for the two-bit symbol line codec
// depends on tbslc_pkg and the two_bit_symbol_line_codec rtl; drives a stimulus table,
// then random buffers under several settings, checked against a built-in codec predictor
module two_bit_symbol_line_codec_test;

  // run guard and settle time after the last result
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PER_PHASE = 68;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  tbslc_pkg::in_t             in_item;
  logic                       out_valid;
  logic                       out_ready;
  tbslc_pkg::out_t            out_item;
  logic                       cfg_we;
  logic [1:0]                 cfg_index;
  logic [tbslc_pkg::MapW-1:0] cfg_data;

  two_bit_symbol_line_codec DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // one row of the directed table; n_typed < 0 means the predictor supplies the results,
  // otherwise typed_bytes holds them, first result in the top byte
  typedef struct {
    tbslc_pkg::in_t item;
    int             n_typed;
    logic [31:0]    typed_bytes;
  } dir_row_t;

  dir_row_t dir_rows[$];

  // expected results, oldest first
  tbslc_pkg::out_t awaited_bytes[$];

  // results worked out for the transaction just accepted
  tbslc_pkg::out_t predicted[4];

  // shadow copy of the configuration registers
  logic [tbslc_pkg::MapW-1:0]   shadow_map;
  logic                         shadow_msb;
  logic [tbslc_pkg::AlignW-1:0] shadow_align;

  // predictor copy of the decode state
  logic [1:0] skip_left_q;
  logic [1:0] group_cnt_q;
  logic [5:0] group_bits_q;
  logic       halted_q;
  logic       at_buf_start;

  int  cycle_count;
  int  mismatches;
  int  items_sent;
  int  results_checked;
  int  phases_run;
  // high while neither side may idle
  logic calm_run;

  // clock, 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, awaited_bytes.size());
      $display("[two_bit_symbol_line_codec] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    // keep the log short when the design is badly off, but count every one
    if (mismatches < 100)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic int pair_lookup(logic [7:0] sym);
    // duplicate symbols: the lowest pair wins
    for (int k = 0; k < 4; k++) begin
      if (shadow_map[8*k +: 8] == sym)
        return k;
    end
    return -1;
  endfunction

  function automatic void reset_codec_model();
    shadow_map   = tbslc_pkg::SYMBOL_MAP_RESET;
    shadow_msb   = tbslc_pkg::FIRST_HIGH_RESET;
    shadow_align = tbslc_pkg::ALIGN_RESET;
    skip_left_q  = '0;
    group_cnt_q  = '0;
    group_bits_q = '0;
    halted_q     = 1'b0;
    at_buf_start = 1'b1;
  endfunction

  // fills predicted[] for one accepted transaction and returns how many results it gives
  function automatic int predict_codec_outputs(tbslc_pkg::in_t it);
    int         shift;
    int         q;
    int         n;
    logic [1:0] pair;
    logic [7:0] v;
    n = 0;
    if (it.action == tbslc_pkg::ACT_ENCODE) begin
      // four symbols, run_last on the fourth; decode state untouched, last ignored
      for (int k = 0; k < 4; k++) begin
        shift = shadow_msb ? 6 - 2*k : 2*k;
        pair = it.data[shift +: 2];
        predicted[k].out_byte = shadow_map[8*int'(pair) +: 8];
        predicted[k].run_last = (k == 3);
      end
      return 4;
    end
    // align is only picked up when a buffer opens
    if (at_buf_start) begin
      skip_left_q  = shadow_align;
      at_buf_start = 1'b0;
    end
    if (!halted_q) begin
      if (skip_left_q != 0) begin
        skip_left_q = skip_left_q - 1'b1;
      end else begin
        q = pair_lookup(it.data);
        if (q < 0) begin
          // unknown symbol: drop the group and stay quiet until last
          halted_q     = 1'b1;
          group_cnt_q  = '0;
          group_bits_q = '0;
        end else if (group_cnt_q < 3) begin
          group_bits_q = {group_bits_q[3:0], q[1:0]};
          group_cnt_q  = group_cnt_q + 1'b1;
        end else begin
          // bit order is read when the fourth symbol lands
          if (shadow_msb)
            v = {group_bits_q, q[1:0]};
          else
            v = {q[1:0], group_bits_q[1:0], group_bits_q[3:2], group_bits_q[5:4]};
          predicted[0].out_byte = v;
          predicted[0].run_last = 1'b1;
          n = 1;
          group_cnt_q  = '0;
          group_bits_q = '0;
        end
      end
    end
    // end of buffer: a trailing partial group is dropped
    if (it.last) begin
      group_cnt_q  = '0;
      group_bits_q = '0;
      halted_q     = 1'b0;
      skip_left_q  = '0;
      at_buf_start = 1'b1;
    end
    return n;
  endfunction

  // ---------------------------------------------------------------- input side

  // offers one transaction, waits for it to be taken, then queues what it should give
  task automatic send_item(tbslc_pkg::in_t it, int n_typed, logic [31:0] typed_bytes);
    int              n;
    tbslc_pkg::out_t r;
    while (!calm_run && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    // the predictor always runs so its state follows the stream
    n = predict_codec_outputs(it);
    if (n_typed < 0) begin
      for (int k = 0; k < n; k++)
        awaited_bytes.push_back(predicted[k]);
    end else begin
      for (int k = 0; k < n_typed; k++) begin
        r.out_byte = typed_bytes[31 - 8*k -: 8];
        r.run_last = (k == n_typed - 1);
        awaited_bytes.push_back(r);
      end
    end
  endtask

  // stop offering, let every awaited result arrive, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all three registers on consecutive edges; only called while idle
  task automatic apply_settings(logic [tbslc_pkg::MapW-1:0] map, logic msb,
                                logic [tbslc_pkg::AlignW-1:0] aln);
    cfg_we    <= 1'b1;
    cfg_index <= tbslc_pkg::REG_SYMBOL_MAP;
    cfg_data  <= map;
    @(posedge clk);
    cfg_index <= tbslc_pkg::REG_FIRST_HIGH;
    cfg_data  <= {{(tbslc_pkg::MapW-1){1'b0}}, msb};
    @(posedge clk);
    cfg_index <= tbslc_pkg::REG_ALIGN;
    cfg_data  <= {{(tbslc_pkg::MapW-tbslc_pkg::AlignW){1'b0}}, aln};
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_map   = map;
    shadow_msb   = msb;
    shadow_align = aln;
    phases_run++;
  endtask

  function automatic logic [31:0] distinct_map();
    logic [7:0] s[4];
    bit         clash;
    for (int k = 0; k < 4; k++) begin
      do begin
        s[k] = 8'($urandom_range(0, 255));
        clash = 1'b0;
        for (int j = 0; j < k; j++)
          if (s[j] == s[k]) clash = 1'b1;
      end while (clash);
    end
    return {s[3], s[2], s[1], s[0]};
  endfunction

  function automatic tbslc_pkg::in_t rand_encode();
    tbslc_pkg::in_t it;
    it.action = tbslc_pkg::ACT_ENCODE;
    it.data   = 8'($urandom_range(0, 255));
    it.last   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // random buffers: mostly symbols from the current map, some noise bytes,
  // stray encodes inside buffers and now and then a buffer left open
  task automatic run_random(int n_items, int pause_at);
    int             start;
    int             len;
    int             sel;
    bit             paused;
    tbslc_pkg::in_t it;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < n_items) begin
      if (!paused && pause_at >= 0 && items_sent - start >= pause_at) begin
        // hold the sender until the output side has caught up completely
        wait_idle();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 15) begin
        send_item(rand_encode(), -1, '0);
      end else begin
        len = $urandom_range(1, 14);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < 8)
            send_item(rand_encode(), -1, '0);
          sel = $urandom_range(0, 3);
          it.action = tbslc_pkg::ACT_DECODE;
          if ($urandom_range(0, 99) < 88)
            it.data = shadow_map[8*sel +: 8];
          else
            it.data = 8'($urandom_range(0, 255));
          it.last = (k == len - 1) && ($urandom_range(0, 99) < 92);
          send_item(it, -1, '0);
        end
      end
    end
  endtask

  function automatic dir_row_t mk_row(tbslc_pkg::action_t act, logic [7:0] d, logic l,
                                      int n, logic [31:0] b);
    dir_row_t r;
    r.item.action = act;
    r.item.data   = d;
    r.item.last   = l;
    r.n_typed     = n;
    r.typed_bytes = b;
    return r;
  endfunction

  // ---------------------------------------------------------------- output side

  // checks each result transaction against the oldest expectation, then picks
  // the next ready level
  always @(posedge clk) begin : rx_check
    tbslc_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h run_last %0b",
                                  out_item.out_byte, out_item.run_last));
      end else begin
        want = awaited_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                    out_item.out_byte, want.out_byte));
        if (out_item.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %0b, wanted %0b on byte %02h",
                                    out_item.run_last, want.run_last, want.out_byte));
        results_checked++;
      end
    end
    out_ready <= calm_run || ($urandom_range(0, 99) >= 35);
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    logic [31:0] dup_map;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm_run  = 1'b0;
    cycle_count     = 0;
    mismatches      = 0;
    items_sent      = 0;
    results_checked = 0;
    phases_run      = 1;
    reset_codec_model();

    // reset map: pair 00 = ff, 01 = df, 10 = fb, 11 = db; msb first; no skip
    // encodes right after reset, extremes and all four pairs
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_ENCODE, 8'h00, 1'b0, 4, 32'hFFFF_FFFF));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_ENCODE, 8'hFF, 1'b1, 4, 32'hDBDB_DBDB));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_ENCODE, 8'h1B, 1'b0, 4, 32'hFFDF_FBDB));
    // one clean group, every pair once
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hFF, 1'b0, 0, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hDF, 1'b0, 0, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hFB, 1'b0, 0, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hDB, 1'b1, 1, 32'h1B00_0000));
    // all ones
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hDB, 1'b0, 0, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hDB, 1'b0, 0, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hDB, 1'b0, 0, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hDB, 1'b1, 1, 32'hFF00_0000));
    // unknown symbol halts the rest of the buffer
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'h00, 1'b0, 0, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hFF, 1'b0, 0, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hFF, 1'b1, 0, '0));
    // decoding resumes in the next buffer
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hFF, 1'b0, 0, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hFF, 1'b0, 0, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hFF, 1'b0, 0, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hDF, 1'b1, 1, 32'h0100_0000));
    // an encode with last set inside a group leaves the group alone
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hFB, 1'b0, -1, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_ENCODE, 8'hA5, 1'b1, -1, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hFB, 1'b0, -1, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hFB, 1'b0, -1, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hFB, 1'b1, -1, '0));
    // trailing partial group is dropped
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hDF, 1'b0, -1, '0));
    dir_rows.push_back(mk_row(tbslc_pkg::ACT_DECODE, 8'hDF, 1'b1, -1, '0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].n_typed, dir_rows[i].typed_bytes);
    run_random(RANDOM_PER_PHASE, -1);

    // every map entry the same, lsb first, largest skip
    wait_idle();
    apply_settings(32'hFFFF_FFFF, 1'b0, 2'd3);
    run_random(RANDOM_PER_PHASE, -1);

    // fresh distinct map; the sender also pauses here until the output is drained
    wait_idle();
    apply_settings(distinct_map(), 1'b1, 2'd1);
    run_random(RANDOM_PER_PHASE, 30);

    // all-zero map and no idling on either side
    wait_idle();
    calm_run <= 1'b1;
    apply_settings(32'h0000_0000, 1'b0, 2'd0);
    run_random(RANDOM_PER_PHASE, -1);
    wait_idle();
    calm_run <= 1'b0;

    // random map with pairs 00 and 10 sharing a symbol
    dup_map = $urandom;
    dup_map[23:16] = dup_map[7:0];
    apply_settings(dup_map, 1'b1, 2'd2);
    run_random(RANDOM_PER_PHASE, -1);

    wait_idle();
    apply_settings(distinct_map(), 1'b0, 2'd3);
    run_random(RANDOM_PER_PHASE, -1);

    wait_idle();
    $display("covered %0d input transactions and %0d result transactions over %0d settings",
             items_sent, results_checked, phases_run);
    $display("directed table of %0d rows, then random buffers; %0d mismatches",
             dir_rows.size(), mismatches);
    if (mismatches == 0) begin
      $display("[two_bit_symbol_line_codec] OK");
    end else begin
      $display("[two_bit_symbol_line_codec] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tbslc_pkg.sv
rtl/core/tbslc_encoder.sv
rtl/core/tbslc_decoder.sv
rtl/core/tbslc_out_ser.sv
rtl/core/two_bit_symbol_line_codec.sv
sim/two_bit_symbol_line_codec_test.sv
